// File: design/line_rasterizer_defines.svh
// ----------------------------------------------------------------------------
// line_rasterizer_defines.svh
// assertion macros shared by the line rasterizer rtl
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// implication checked every clock edge outside reset
`define LR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("line rasterizer assertion failed");
// same check, also active while reset is asserted
`define LR_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("line rasterizer assertion failed");
`else
`define LR_ASSERT(label, prop)
`define LR_ASSERT_ALWAYS(label, prop)
`endif

`endif

// File: design/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg
// shared types and constants of the line rasterizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

  // default coordinate width
  localparam int COORD_BITS_DEF = 10;

  // request kinds on the input channel
  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_type_t;

endpackage

`default_nettype wire

// File: design/lr_if.sv
// ----------------------------------------------------------------------------
// lr_in_if / lr_out_if
// valid/ready channels for line requests and pixel results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lr_in_if #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  lr_pkg::req_type_t     req_type;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (output valid, req_type, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, req_type, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lr_out_if #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  last_pixel;

  modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

`default_nettype wire

// File: design/line_rasterizer.sv
// ----------------------------------------------------------------------------
// line_rasterizer
// bresenham line rasterizer: a load request latches two endpoints, each
// step request emits the next pixel of the line
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_req    in   valid/ready    req_type, start_x, start_y, end_x, end_y
//  out_res   out  valid/ready    pixel_x, pixel_y, last_pixel
//
//  one request per clock unless a held result stalls: a request waits in the
//  input register, then its pixel moves into the result register
//  the throughput limit is the single add/compare of the error update
//  a held result stalls only step requests that produce a pixel; loads and
//  steps with no line active pass through while the result waits
//  reset (rst_n low, synchronous) drops any line and any queued request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "line_rasterizer_defines.svh"

module line_rasterizer #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  lr_in_if.sink    in_req,
  lr_out_if.source out_res
);
  import lr_pkg::*;

  localparam int ErrBits = COORD_BITS + 2;

  typedef logic [COORD_BITS-1:0]     coord_t;
  typedef logic signed [ErrBits-1:0] err_t;

  // input register
  logic      s1_valid_r;
  req_type_t s1_req_type_r;
  coord_t    s1_sx_r, s1_sy_r, s1_ex_r, s1_ey_r;

  // line state
  coord_t cur_major_r, cur_minor_r, stop_major_r;
  coord_t delta_major_r, delta_minor_r;
  err_t   error_term_r;
  logic   minor_down_r, steep_line_r, line_active_r;

  // result register
  logic   out_valid_r;
  coord_t pixel_x_r, pixel_y_r;
  logic   last_pixel_r;

  // handshake control
  logic in_accept, s1_emits, s1_adv;

  // load decode
  coord_t ld_dx, ld_dy;
  logic   ld_steep, ld_swap;
  coord_t ld_a_maj, ld_a_min, ld_b_maj, ld_b_min;
  coord_t ld_dmaj, ld_dmin;
  err_t   ld_err;

  // step update
  logic   st_last;
  err_t   st_err;
  coord_t st_minor;

  // a pixel is produced only by a step request while a line is live
  assign s1_emits  = (s1_req_type_r == REQ_STEP) && line_active_r;
  // the input register drains unless its pixel has nowhere to go
  assign s1_adv    = s1_valid_r && (!s1_emits || !out_valid_r || out_res.ready);
  assign in_req.ready = !s1_valid_r || s1_adv;
  assign in_accept = in_req.valid && in_req.ready;

  assign out_res.valid      = out_valid_r;
  assign out_res.pixel_x    = pixel_x_r;
  assign out_res.pixel_y    = pixel_y_r;
  assign out_res.last_pixel = last_pixel_r;

  // load: pick major axis, order endpoints along it, seed the error term
  always_comb begin
    ld_dx    = (s1_sx_r > s1_ex_r) ? s1_sx_r - s1_ex_r : s1_ex_r - s1_sx_r;
    ld_dy    = (s1_sy_r > s1_ey_r) ? s1_sy_r - s1_ey_r : s1_ey_r - s1_sy_r;
    ld_steep = ld_dy > ld_dx;   // equal slopes walk along x
    if (ld_steep) begin
      ld_a_maj = s1_sy_r; ld_a_min = s1_sx_r;
      ld_b_maj = s1_ey_r; ld_b_min = s1_ex_r;
      ld_dmaj  = ld_dy;   ld_dmin  = ld_dx;
    end else begin
      ld_a_maj = s1_sx_r; ld_a_min = s1_sy_r;
      ld_b_maj = s1_ex_r; ld_b_min = s1_ey_r;
      ld_dmaj  = ld_dx;   ld_dmin  = ld_dy;
    end
    ld_swap = ld_b_maj < ld_a_maj;
    // 2*dminor - dmajor
    ld_err  = $signed({1'b0, ld_dmin, 1'b0}) - $signed({2'b00, ld_dmaj});
  end

  // step: advance one pixel along the major axis
  always_comb begin
    st_last  = cur_major_r == stop_major_r;
    st_minor = cur_minor_r;
    if (error_term_r[ErrBits-1]) begin
      // negative error: minor coordinate holds
      st_err = error_term_r + $signed({1'b0, delta_minor_r, 1'b0});
    end else begin
      st_err = error_term_r + $signed({1'b0, delta_minor_r, 1'b0})
               - $signed({1'b0, delta_major_r, 1'b0});
      st_minor = minor_down_r ? cur_minor_r - coord_t'(1) : cur_minor_r + coord_t'(1);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_type_r <= in_req.req_type;
      s1_sx_r       <= in_req.start_x;
      s1_sy_r       <= in_req.start_y;
      s1_ex_r       <= in_req.end_x;
      s1_ey_r       <= in_req.end_y;
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_major_r   <= '0;
      cur_minor_r   <= '0;
      stop_major_r  <= '0;
      delta_major_r <= '0;
      delta_minor_r <= '0;
      error_term_r  <= '0;
      minor_down_r  <= 1'b0;
      steep_line_r  <= 1'b0;
      line_active_r <= 1'b0;
    end else if (s1_adv) begin
      if (s1_req_type_r == REQ_LOAD) begin
        // a load replaces any line still in progress
        cur_major_r   <= ld_swap ? ld_b_maj : ld_a_maj;
        cur_minor_r   <= ld_swap ? ld_b_min : ld_a_min;
        stop_major_r  <= ld_swap ? ld_a_maj : ld_b_maj;
        minor_down_r  <= ld_swap ? (ld_a_min < ld_b_min) : (ld_b_min < ld_a_min);
        delta_major_r <= ld_dmaj;
        delta_minor_r <= ld_dmin;
        error_term_r  <= ld_err;
        steep_line_r  <= ld_steep;
        line_active_r <= 1'b1;
      end else if (line_active_r) begin
        if (st_last) begin
          line_active_r <= 1'b0;
        end else begin
          error_term_r <= st_err;
          cur_minor_r  <= st_minor;
          cur_major_r  <= cur_major_r + coord_t'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_emits) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emits) begin
      pixel_x_r    <= steep_line_r ? cur_minor_r : cur_major_r;
      pixel_y_r    <= steep_line_r ? cur_major_r : cur_minor_r;
      last_pixel_r <= st_last;
    end
  end

  // a held result is never overwritten by a new pixel
  `LR_ASSERT(a_no_overwrite, (out_valid_r && !out_res.ready) |-> !(s1_adv && s1_emits))
  // emitting the far endpoint ends the line
  `LR_ASSERT(a_last_ends_line, (s1_adv && s1_emits && st_last) |=> !line_active_r)
  // a load always leaves a line active
  `LR_ASSERT(a_load_starts_line, (s1_adv && s1_req_type_r == REQ_LOAD) |=> line_active_r)
  // the walk never passes the far endpoint
  `LR_ASSERT_ALWAYS(a_walk_bounded, line_active_r |-> (cur_major_r <= stop_major_r))
  // a new result only follows a pixel-producing request
  `LR_ASSERT(a_result_source, $rose(out_valid_r) |-> $past(s1_adv && s1_emits))

endmodule

`default_nettype wire

// File: tb/line_rasterizer_tb.sv
// ----------------------------------------------------------------------------
// line_rasterizer_tb
// self-checking bench for the line rasterizer: a short table of directed
// requests, then random lines stepped through to their end (some cut short,
// some stepped past the end, some noise), with random gaps on both channels
// every accepted request goes through a local line walker and every pixel
// is compared field by field with the oldest expected pixel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_rasterizer_tb;
  import lr_pkg::*;

  localparam int CB         = COORD_BITS_DEF;
  localparam int MAXC       = (1 << CB) - 1;
  localparam int RAND_ITEMS = 1450;

  typedef struct packed {
    req_type_t     kind;
    logic [CB-1:0] sx;
    logic [CB-1:0] sy;
    logic [CB-1:0] ex;
    logic [CB-1:0] ey;
  } line_req_t;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          last;
  } pixel_t;

  // where the expected pixel of a request comes from
  typedef enum {
    CHK_MODEL,   // local line walker
    CHK_NONE,    // typed in: no pixel
    CHK_PIXEL    // typed in: this pixel
  } check_mode_t;

  typedef struct {
    line_req_t   req;
    check_mode_t how;
    pixel_t      want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  lr_in_if  #(.COORD_BITS(CB)) in_ch  ();
  lr_out_if #(.COORD_BITS(CB)) out_ch ();

  line_rasterizer #(.COORD_BITS(CB)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch),
    .out_res (out_ch)
  );

  // line walker state, zero after reset like the block
  logic [CB-1:0] walk_major = '0;
  logic [CB-1:0] walk_minor = '0;
  logic [CB-1:0] far_major  = '0;
  int            span_major = 0;
  int            span_minor = 0;
  int            decision   = 0;
  bit            minor_dec  = 1'b0;
  bit            is_steep   = 1'b0;
  bit            drawing    = 1'b0;

  pixel_t   pending_pixels [$];
  dir_row_t dir_rows [$];
  int       mismatches = 0;
  int       work_items = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(20_000_000);
    $display("line_rasterizer_tb: errors");
    $finish;
  end

  // gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // apply one accepted request to the walker, return the pixel it yields
  function automatic void next_pixel(input line_req_t r, output bit got, output pixel_t px);
    int            dx;
    int            dy;
    logic [CB-1:0] a_maj;
    logic [CB-1:0] a_min;
    logic [CB-1:0] b_maj;
    logic [CB-1:0] b_min;
    got = 1'b0;
    px  = '0;
    if (r.kind == REQ_LOAD) begin
      dx = (r.sx > r.ex) ? int'(r.sx) - int'(r.ex) : int'(r.ex) - int'(r.sx);
      dy = (r.sy > r.ey) ? int'(r.sy) - int'(r.ey) : int'(r.ey) - int'(r.sy);
      // ties go to the shallow walk
      is_steep = dy > dx;
      if (is_steep) begin
        a_maj = r.sy; a_min = r.sx; b_maj = r.ey; b_min = r.ex;
        span_major = dy; span_minor = dx;
      end else begin
        a_maj = r.sx; a_min = r.sy; b_maj = r.ex; b_min = r.ey;
        span_major = dx; span_minor = dy;
      end
      // always walk up the major axis
      if (b_maj < a_maj) begin
        {a_maj, b_maj} = {b_maj, a_maj};
        {a_min, b_min} = {b_min, a_min};
      end
      walk_major = a_maj;
      walk_minor = a_min;
      far_major  = b_maj;
      minor_dec  = b_min < a_min;
      decision   = 2 * span_minor - span_major;
      drawing    = 1'b1;
    end else if (drawing) begin
      got    = 1'b1;
      px.x   = is_steep ? walk_minor : walk_major;
      px.y   = is_steep ? walk_major : walk_minor;
      px.last = (walk_major == far_major);
      if (px.last) begin
        drawing = 1'b0;
      end else begin
        if (decision < 0) begin
          decision += 2 * span_minor;
        end else begin
          decision += 2 * (span_minor - span_major);
          walk_minor = minor_dec ? walk_minor - 1'b1 : walk_minor + 1'b1;
        end
        walk_major = walk_major + 1'b1;
      end
    end
  endfunction

  function automatic void add_row(input req_type_t k, input int sx, input int sy,
                                  input int ex, input int ey, input check_mode_t how,
                                  input int x = 0, input int y = 0, input bit last = 1'b0);
    dir_row_t row;
    row.req.kind = k;
    row.req.sx   = CB'(sx);
    row.req.sy   = CB'(sy);
    row.req.ex   = CB'(ex);
    row.req.ey   = CB'(ey);
    row.how      = how;
    row.want.x   = CB'(x);
    row.want.y   = CB'(y);
    row.want.last = last;
    dir_rows.push_back(row);
  endfunction

  // coordinate within spread of c, clamped to the raster
  function automatic logic [CB-1:0] near(input logic [CB-1:0] c, input int spread);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > MAXC) v = MAXC;
    return CB'(v);
  endfunction

  function automatic logic [CB-1:0] rim();
    return $urandom_range(0, 1) ? CB'(MAXC) : '0;
  endfunction

  function automatic logic [CB-1:0] any_coord();
    return CB'($urandom_range(0, MAXC));
  endfunction

  // drive one request, hold it until accepted, then book its pixel
  task automatic send_req(input line_req_t r, input check_mode_t how, input pixel_t want,
                          input bit calm);
    bit     got;
    pixel_t px;
    int     gap;
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= r.kind;
    in_ch.start_x  <= r.sx;
    in_ch.start_y  <= r.sy;
    in_ch.end_x    <= r.ex;
    in_ch.end_y    <= r.ey;
    do @(posedge clk); while (!in_ch.ready);
    // steps with no line active are ignored and not counted
    if (r.kind == REQ_LOAD || drawing) work_items++;
    next_pixel(r, got, px);
    case (how)
      CHK_MODEL: if (got) pending_pixels.push_back(px);
      CHK_PIXEL: pending_pixels.push_back(want);
      default: ;
    endcase
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: runs of ready, broken by gaps of random length
  initial begin
    int hold;
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
      out_ch.ready <= 1'b1;
      repeat (hold) @(posedge clk);
      gap = idle_len();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // pixel checker
  always @(posedge clk) begin
    pixel_t seen;
    pixel_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.x    = out_ch.pixel_x;
      seen.y    = out_ch.pixel_y;
      seen.last = out_ch.last_pixel;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel x=%0d y=%0d last=%0d at %0t",
                   seen.x, seen.y, seen.last, $realtime);
      end else begin
        want = pending_pixels.pop_front();
        if (seen.x !== want.x || seen.y !== want.y || seen.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"pixel mismatch at %0t: want x=%0d y=%0d last=%0d, ",
                      "got x=%0d y=%0d last=%0d"},
                     $realtime, want.x, want.y, want.last, seen.x, seen.y, seen.last);
        end
      end
    end
  end

  initial begin
    line_req_t r;
    bit        calm;
    int        pick;
    int        dx;
    int        dy;
    int        steps;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= REQ_LOAD;
    in_ch.start_x  <= '0;
    in_ch.start_y  <= '0;
    in_ch.end_x    <= '0;
    in_ch.end_y    <= '0;
    rst_n          <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // step with no line active after reset
    add_row(REQ_STEP, MAXC, MAXC, MAXC, MAXC, CHK_NONE);
    // single-point lines at both corners
    add_row(REQ_LOAD, 0, 0, 0, 0, CHK_NONE);
    add_row(REQ_STEP, MAXC, 0, MAXC, 0, CHK_PIXEL, 0, 0, 1'b1);
    add_row(REQ_STEP, 0, 0, 0, 0, CHK_NONE);
    add_row(REQ_LOAD, MAXC, MAXC, MAXC, MAXC, CHK_NONE);
    add_row(REQ_STEP, 0, 0, 0, 0, CHK_PIXEL, MAXC, MAXC, 1'b1);
    // full-width horizontal line, dropped after two pixels
    add_row(REQ_LOAD, 0, 0, MAXC, 0, CHK_NONE);
    add_row(REQ_STEP, 0, 0, 0, 0, CHK_PIXEL, 0, 0, 1'b0);
    add_row(REQ_STEP, 0, 0, 0, 0, CHK_PIXEL, 1, 0, 1'b0);
    // load over an active line: vertical, walked from the smaller y
    add_row(REQ_LOAD, MAXC, MAXC, MAXC, MAXC - 3, CHK_NONE);
    add_row(REQ_STEP, 0, 0, 0, 0, CHK_PIXEL, MAXC, MAXC - 3, 1'b0);
    add_row(REQ_STEP, 0, 0, 0, 0, CHK_MODEL);
    add_row(REQ_STEP, 0, 0, 0, 0, CHK_MODEL);
    add_row(REQ_STEP, 0, 0, 0, 0, CHK_PIXEL, MAXC, MAXC, 1'b1);
    // equal slopes go shallow; minor axis walks down
    add_row(REQ_LOAD, 5, 0, 0, 5, CHK_NONE);
    add_row(REQ_STEP, 0, 0, 0, 0, CHK_PIXEL, 0, 5, 1'b0);
    add_row(REQ_STEP, 0, 0, 0, 0, CHK_MODEL);
    add_row(REQ_STEP, 0, 0, 0, 0, CHK_MODEL);
    // steep line given top end first
    add_row(REQ_LOAD, 2, 9, 0, 0, CHK_NONE);
    add_row(REQ_STEP, 0, 0, 0, 0, CHK_PIXEL, 0, 0, 1'b0);
    add_row(REQ_STEP, 0, 0, 0, 0, CHK_MODEL);
    add_row(REQ_STEP, 0, 0, 0, 0, CHK_MODEL);
    add_row(REQ_STEP, 0, 0, 0, 0, CHK_MODEL);
    // full-diagonal anti-slope, starts from the smaller x
    add_row(REQ_LOAD, MAXC, 0, 0, MAXC, CHK_NONE);
    add_row(REQ_STEP, 0, 0, 0, 0, CHK_PIXEL, 0, MAXC, 1'b0);

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].how, dir_rows[i].want, 1'b0);

    // random lines, mostly short ones stepped to their end
    work_items = 0;
    while (work_items < RAND_ITEMS) begin
      calm = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 99);
      if (pick >= 94) begin
        // noise: random request kinds and fields
        repeat ($urandom_range(1, 4)) begin
          r.kind = req_type_t'($urandom_range(0, 1));
          r.sx = any_coord(); r.sy = any_coord(); r.ex = any_coord(); r.ey = any_coord();
          send_req(r, CHK_MODEL, '0, calm);
        end
      end else begin
        r.kind = REQ_LOAD;
        r.sx = any_coord();
        r.sy = any_coord();
        if (pick < 72) begin
          r.ex = near(r.sx, 12);
          r.ey = near(r.sy, 12);
        end else if (pick < 84) begin
          r.ex = any_coord();
          r.ey = any_coord();
        end else begin
          r.sx = rim(); r.sy = rim(); r.ex = rim(); r.ey = rim();
        end
        send_req(r, CHK_MODEL, '0, calm);
        dx = (r.sx > r.ex) ? int'(r.sx) - int'(r.ex) : int'(r.ex) - int'(r.sx);
        dy = (r.sy > r.ey) ? int'(r.sy) - int'(r.ey) : int'(r.ey) - int'(r.sy);
        steps = ((dx > dy) ? dx : dy) + 1;
        // long lines are mostly dropped early by the next load
        if (steps > 40 && $urandom_range(0, 29) != 0)
          steps = $urandom_range(1, 24);
        else if ($urandom_range(0, 9) == 0)
          steps = $urandom_range(1, steps);
        else if ($urandom_range(0, 6) == 0)
          steps += $urandom_range(1, 2);
        r.kind = REQ_STEP;
        repeat (steps) begin
          r.sx = any_coord(); r.sy = any_coord(); r.ex = any_coord(); r.ey = any_coord();
          send_req(r, CHK_MODEL, '0, calm);
        end
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_pixels.size() != 0) @(posedge clk);
    // catch any stray pixel behind the last one
    repeat (10) @(posedge clk);

    if (pending_pixels.size() != 0) begin
      mismatches += pending_pixels.size();
      $display("%0d expected pixels never arrived", pending_pixels.size());
    end
    if (mismatches == 0) begin
      $display("line_rasterizer_tb: clean");
    end else begin
      $display("line_rasterizer_tb: errors");
    end
    $finish;
  end

endmodule
